// ===== rtl/tach_pkg.sv =====
// ----------------------------------------------------------------------------
// tach_pkg: shared definitions for the tachometer block
// Request codes, register indexes, reset values and the command and status
// structs passed between controller and datapath.
// ----------------------------------------------------------------------------
package tach_pkg;

  // request kinds carried in the low bits of s_tuser
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_PULSE = 2'd1;
  localparam logic [1:0] REQ_SPI   = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_TIMEOUT   = 2'd0;
  localparam logic [1:0] CFG_NUMERATOR = 2'd1;
  localparam logic [1:0] CFG_LIMIT     = 2'd2;
  localparam logic [1:0] CFG_COMMAND   = 2'd3;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  // register reset values
  localparam logic [15:0] TIMEOUT_RST   = 16'd1000;
  localparam logic [15:0] NUMERATOR_RST = 16'd60000;
  localparam logic [15:0] LIMIT_RST     = 16'd1500;
  localparam logic [7:0]  COMMAND_RST   = 8'h49;  // 'I'

  // report frame
  localparam int         FRAME_BYTES = 7;
  localparam logic [7:0] CH_OPEN     = 8'h5B;  // '['
  localparam logic [7:0] CH_R        = 8'h52;  // 'R'
  localparam logic [7:0] CH_A        = 8'h41;  // 'A'
  localparam logic [7:0] CH_B        = 8'h42;  // 'B'
  localparam logic [7:0] CH_COMMA    = 8'h2C;  // ','
  localparam logic [7:0] CH_CLOSE    = 8'h5D;  // ']'

  // stream payload widths
  localparam int S_TDATA_W = 8;
  localparam int S_TUSER_W = 3;
  localparam int M_TDATA_W = 32;
  localparam int M_TUSER_W = 1;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic start_div;
    logic div_step;
    logic commit;
  } tach_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_free;
  } tach_status_t;

endpackage

// ===== rtl/tach_ctrl.sv =====
// ----------------------------------------------------------------------------
// tach_ctrl: sequencing of one item
// Takes an item, runs the serial divider when a pulse needs it, then commits
// the update and loads the output register once that is free.
// ----------------------------------------------------------------------------
module tach_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  tach_pkg::tach_status_t status,
  output tach_pkg::tach_cmd_t    cmd
);
  import tach_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign s_tready = (state == ST_IDLE);

  // next state and commands
  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.load_in   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.need_div) begin
          cmd.start_div = 1'b1;
          state_next    = ST_DIV;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/tach_dp.sv =====
// ----------------------------------------------------------------------------
// tach_dp: tachometer datapath
// Configuration registers, period counter, speed and sensor state, report
// frame state, a 16-step restoring divider and the output register.
// ----------------------------------------------------------------------------
module tach_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [tach_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [tach_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [tach_pkg::S_TDATA_W-1:0]    s_tdata,
  input  logic [tach_pkg::S_TUSER_W-1:0]    s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [tach_pkg::M_TDATA_W-1:0]    m_tdata,
  output logic [tach_pkg::M_TUSER_W-1:0]    m_tuser,
  output logic                              m_tlast,
  input  tach_pkg::tach_cmd_t               cmd,
  output tach_pkg::tach_status_t            status
);
  import tach_pkg::*;

  // configuration
  logic [15:0] timeout_ticks;
  logic [15:0] rpm_numerator;
  logic [15:0] overspeed_limit;
  logic [7:0]  command_byte;

  // measurement and frame state
  logic [15:0] tick_count,  tick_count_next;
  logic [15:0] speed_value, speed_value_next;
  logic        sensor_sel,  sensor_sel_next;
  logic [15:0] snap_rpm,    snap_rpm_next;
  logic        snap_sensor, snap_sensor_next;
  logic        frame_pending, frame_pending_next;
  logic [2:0]  frame_index, frame_index_next;

  // latched item
  logic [1:0]  req;
  logic        pulse_sensor;
  logic [7:0]  rx_byte;

  // divider
  logic [15:0] div_rem;
  logic [15:0] div_quo;
  logic [15:0] div_den;
  logic [3:0]  div_cnt;
  logic [16:0] div_shift;
  logic [16:0] div_diff;

  // result
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        frame_last;
  logic [15:0] tick_inc;

  function automatic logic [7:0] frame_byte(input logic [2:0] idx, input logic snap_s,
                                            input logic [15:0] snap_r);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = CH_OPEN;
      3'd1:    b = CH_R;
      3'd2:    b = snap_s ? CH_B : CH_A;
      3'd3:    b = CH_COMMA;
      3'd4:    b = snap_r[7:0];
      3'd5:    b = snap_r[15:8];
      default: b = CH_CLOSE;
    endcase
    return b;
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks   <= TIMEOUT_RST;
      rpm_numerator   <= NUMERATOR_RST;
      overspeed_limit <= LIMIT_RST;
      command_byte    <= COMMAND_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_TIMEOUT:   timeout_ticks   <= cfg_data;
        CFG_NUMERATOR: rpm_numerator   <= cfg_data;
        CFG_LIMIT:     overspeed_limit <= cfg_data;
        CFG_COMMAND:   command_byte    <= cfg_data[7:0];
        default:       ;
      endcase
    end
  end

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      req          <= s_tuser[1:0];
      pulse_sensor <= s_tuser[2];
      rx_byte      <= s_tdata[7:0];
    end
  end

  // restoring divider, one quotient bit per cycle
  assign div_shift = {div_rem, div_quo[15]};
  assign div_diff  = div_shift - {1'b0, div_den};

  always_ff @(posedge clk) begin
    if (cmd.start_div) begin
      div_rem <= '0;
      div_quo <= rpm_numerator;
      div_den <= tick_count;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      if (!div_diff[16]) begin
        div_rem <= div_diff[15:0];
        div_quo <= {div_quo[14:0], 1'b1};
      end else begin
        div_rem <= div_shift[15:0];
        div_quo <= {div_quo[14:0], 1'b0};
      end
      div_cnt <= div_cnt + 4'd1;
    end
  end

  // status to controller
  assign status.need_div = (req == REQ_PULSE) && (pulse_sensor == sensor_sel) &&
                           (tick_count != 16'd0);
  assign status.div_last = (div_cnt == 4'd15);
  assign status.out_free = !m_tvalid || m_tready;

  assign tick_inc = tick_count + 16'd1;

  // state update for the latched item
  always_comb begin
    tick_count_next    = tick_count;
    speed_value_next   = speed_value;
    sensor_sel_next    = sensor_sel;
    snap_rpm_next      = snap_rpm;
    snap_sensor_next   = snap_sensor;
    frame_pending_next = frame_pending;
    frame_index_next   = frame_index;
    tx_valid           = 1'b0;
    tx_byte            = 8'd0;
    frame_last         = 1'b0;
    unique case (req)
      REQ_TICK: begin
        if (tick_inc == timeout_ticks) begin
          tick_count_next  = 16'd0;
          speed_value_next = 16'd0;
        end else begin
          tick_count_next = tick_inc;
        end
      end
      REQ_PULSE: begin
        if (pulse_sensor == sensor_sel) begin
          if (tick_count == 16'd0) begin
            speed_value_next = 16'd0;
          end else begin
            speed_value_next = div_quo;
            tick_count_next  = 16'd0;
          end
        end
      end
      REQ_SPI: begin
        if (rx_byte == command_byte) begin
          // snapshot before any sensor switch
          snap_rpm_next      = speed_value;
          snap_sensor_next   = sensor_sel;
          frame_pending_next = 1'b1;
          frame_index_next   = 3'd0;
          if (speed_value > overspeed_limit) begin
            sensor_sel_next = !sensor_sel;
            tick_count_next = 16'd0;
          end
        end else if (frame_pending) begin
          tx_valid = 1'b1;
          tx_byte  = frame_byte(frame_index, snap_sensor, snap_rpm);
          if (frame_index >= 3'(FRAME_BYTES - 1)) begin
            frame_last         = 1'b1;
            frame_pending_next = 1'b0;
            frame_index_next   = 3'd0;
          end else begin
            frame_index_next = frame_index + 3'd1;
          end
        end
      end
      REQ_NONE: ;
      default: ;
    endcase
  end

  // state registers, updated at commit
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count    <= '0;
      speed_value   <= '0;
      sensor_sel    <= 1'b0;
      snap_rpm      <= '0;
      snap_sensor   <= 1'b0;
      frame_pending <= 1'b0;
      frame_index   <= '0;
    end else if (cmd.commit) begin
      tick_count    <= tick_count_next;
      speed_value   <= speed_value_next;
      sensor_sel    <= sensor_sel_next;
      snap_rpm      <= snap_rpm_next;
      snap_sensor   <= snap_sensor_next;
      frame_pending <= frame_pending_next;
      frame_index   <= frame_index_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tdata <= {7'd0, sensor_sel_next, speed_value_next, tx_byte};
      m_tuser <= tx_valid;
      m_tlast <= frame_last;
    end
  end

endmodule

// ===== rtl/tachometer_rpm_with_spi_report.sv =====
// ----------------------------------------------------------------------------
// tachometer_rpm_with_spi_report: period tachometer with SPI report frames
// Top level: controller and datapath joined by command and status structs.
// ----------------------------------------------------------------------------
// Each item is a millisecond tick, a sensor pulse or an SPI byte, and gives
// exactly one result item. A result is loaded into the output register as
// the controller leaves its finish state, after its execute state; only then
// can the next item be taken. A pulse from the active sensor with a nonzero
// period count also passes the divide state, where the restoring divider
// produces one quotient bit per cycle. A result that is not taken holds its
// item in the finish state, and the next item waiting, until the output
// register frees. Configuration writes are taken in any cycle and belong
// while the block is idle. No clearing pass is needed after reset.
module tachometer_rpm_with_spi_report (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_we,
  input  logic [tach_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [tach_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input items
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [tach_pkg::S_TDATA_W-1:0]    s_tdata,  // [7:0] spi_rx_byte
  input  logic [tach_pkg::S_TUSER_W-1:0]    s_tuser,  // [1:0] req_type, [2] pulse_sensor
  // result items
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [tach_pkg::M_TDATA_W-1:0]    m_tdata,  // [7:0] tx_byte, [23:8] speed_rpm,
                                                      // [24] active_sensor, rest zero
  output logic [tach_pkg::M_TUSER_W-1:0]    m_tuser,  // [0] tx_valid
  output logic                              m_tlast   // frame_last
);
  import tach_pkg::*;

  tach_cmd_t    cmd;
  tach_status_t status;

  tach_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tach_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cmd      (cmd),
    .status   (status)
  );

  // busy straight after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("item accepted while previous item in progress");

  // commit only into a free output register
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> status.out_free)
    else $error("result committed over an untaken result");

  // divider only started for an active-sensor pulse with a period
  a_div_needed: assert property (@(posedge clk) disable iff (rst)
    cmd.start_div |-> status.need_div)
    else $error("divider started without need");

  // a new result appears only after a commit
  a_valid_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.commit))
    else $error("result valid without commit");

endmodule
